// ===== rtl/bblur_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_pkg: shared types and constants for the 3x3 RGB box blur
// Item structs for both channels, configuration register codes, field widths
// and the constant divide-by-9 helper.
// ----------------------------------------------------------------------------
package bblur_pkg;

    // Frame geometry
    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int WIDTH_W           = 11;
    localparam int HEIGHT_W          = 13;
    localparam int MAX_HEIGHT        = 4096;
    localparam int RESET_WIDTH       = 800;
    localparam int RESET_HEIGHT      = 600;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Pixel data
    localparam int PIXEL_W = 32;
    localparam int CHAN_W  = 8;
    localparam int RGB_W   = 24;
    localparam int SUM_W   = 12;   // nine bytes: up to 2295
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Operation codes on the input channel
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // floor(x / 9) for x < 2296 as (x * 7282) >> 16
    localparam int DIV9_SHIFT = 16;
    localparam int DIV9_MUL_W = 13;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;
    localparam int DIV9_PROD_W = SUM_W + DIV9_MUL_W;

    typedef struct packed {
        logic               operation;
        logic [PIXEL_W-1:0] pixel_word;
    } pixel_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] blurred_word;
        logic               frame_end;
    } blur_item_t;

    function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] sum);
        logic [DIV9_PROD_W-1:0] prod;
        prod = DIV9_PROD_W'(sum) * DIV9_PROD_W'(DIV9_MUL);
        return prod[DIV9_SHIFT +: CHAN_W];
    endfunction

endpackage

// ===== rtl/box_blur_3x3_rgb_top.sv =====
`timescale 1ns / 1ps
// An accepted item is held in stage 1; the result it causes is loaded into the result
//   register when stage 1 advances and is offered from that register.
// Throughput: one item per cycle, sustained; input stalls only while a result waits.
// Reset: frame size returns to 800x600 and all position counters clear; the line
//   memory is not cleared, since entries not yet written only feed out-of-frame taps.
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_top: 3x3 box blur over a raster stream of RGBA pixels
// Stage 1 holds the accepted item and its line memory read; the 3x3 window,
// neighborhood sums and divide by nine feed the result register.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_top #(
    parameter int MAX_WIDTH = bblur_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [bblur_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  bblur_pkg::pixel_item_t            pixel_item,
    output logic                              blur_valid,
    input  logic                              blur_ready,
    output bblur_pkg::blur_item_t             blur_item
);

    import bblur_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = COL_W + 1;
    localparam int LINE_W = 2 * RGB_W;

    // Configuration
    logic [WIDTH_W-1:0]  frame_width_reg;
    logic [HEIGHT_W-1:0] frame_height_reg;
    logic [EW-1:0]       eff_w;
    logic [HEIGHT_W-1:0] eff_h;

    // Input position
    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [HEIGHT_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]    acc_col;
    logic [HEIGHT_W-1:0] acc_row;
    logic [EW-1:0]       acc_col_inc;
    logic                acc_wrap;
    logic                accept;

    // Stage 1
    logic                s1_valid_reg;
    logic [RGB_W-1:0]    s1_px_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic [HEIGHT_W-1:0] s1_row_reg;
    logic                s1_adv;
    logic                s1_emit;
    logic                s1_last;
    logic                restart;
    logic [LINE_W-1:0]   ram_rdata;
    logic [LINE_W-1:0]   line_rd;
    logic [LINE_W-1:0]   line_wdata;
    logic [RGB_W-1:0]    top_px;
    logic [RGB_W-1:0]    mid_px;
    logic                fwd_hit_reg;
    logic [LINE_W-1:0]   fwd_data_reg;

    // Output position
    logic [COL_W-1:0]    out_col_reg;
    logic [HEIGHT_W-1:0] out_row_reg;
    logic [EW-1:0]       out_col_inc;

    // Window and sums
    logic [RGB_W-1:0]    win_reg [0:8];
    logic [RGB_W-1:0]    win_next [0:8];
    logic [2:0]          row_ok;
    logic [2:0]          col_ok;
    logic [SUM_W-1:0]    sum_r, sum_g, sum_b;
    logic [PIXEL_W-1:0]  blur_word;

    // Output register
    logic                out_valid_reg;
    blur_item_t          out_item_reg;

    // Clamp the frame size to the supported range
    always_comb
    begin
        if (frame_width_reg == '0)
            eff_w = EW'(1);
        else if (int'(frame_width_reg) > MAX_WIDTH)
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = EW'(frame_width_reg);

        if (frame_height_reg == '0)
            eff_h = HEIGHT_W'(1);
        else if (frame_height_reg > HEIGHT_W'(MAX_HEIGHT))
            eff_h = HEIGHT_W'(MAX_HEIGHT);
        else
            eff_h = frame_height_reg;
    end

    // Stage 1 advance and result decision
    assign s1_adv  = s1_valid_reg && (!out_valid_reg || blur_ready);
    assign s1_emit = s1_valid_reg && (s1_row_reg != '0)
                     && ((s1_col_reg != '0) || (s1_row_reg >= HEIGHT_W'(2)))
                     && (out_row_reg < eff_h);
    assign s1_last = ({1'b0, out_col_reg} == (eff_w - EW'(1)))
                     && (out_row_reg == (eff_h - HEIGHT_W'(1)));
    assign restart = s1_adv && s1_emit && s1_last;

    assign pixel_ready = !s1_valid_reg || s1_adv;
    assign accept      = pixel_valid && pixel_ready;

    // Position of the item being accepted; a finishing frame restarts at zero
    always_comb
    begin
        acc_col     = restart ? '0 : in_col_reg;
        acc_row     = restart ? '0 : in_row_reg;
        acc_col_inc = {1'b0, acc_col} + EW'(1);
        acc_wrap    = acc_col_inc >= eff_w;

        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        if (cfg_write)
        begin
            in_col_next = '0;
            in_row_next = '0;
        end
        else if (accept)
        begin
            in_col_next = acc_wrap ? '0 : acc_col_inc[COL_W-1:0];
            in_row_next = acc_wrap ? acc_row + HEIGHT_W'(1) : acc_row;
        end
        else if (restart)
        begin
            in_col_next = '0;
            in_row_next = '0;
        end
    end

    // Line memory: upper half is two rows back, lower half is the previous row
    assign line_rd    = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign top_px     = line_rd[LINE_W-1:RGB_W];
    assign mid_px     = line_rd[RGB_W-1:0];
    assign line_wdata = {mid_px, s1_px_reg};

    bblur_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (acc_col),
        .rdata (ram_rdata)
    );

    // Shift the window one column and bring in the new column
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = top_px;
        win_next[5] = mid_px;
        win_next[8] = s1_px_reg;
    end

    // Neighbors outside the frame drop out of the sums
    always_comb
    begin
        row_ok[0] = out_row_reg != '0;
        row_ok[1] = 1'b1;
        row_ok[2] = ({1'b0, out_row_reg} + (HEIGHT_W+1)'(1)) < {1'b0, eff_h};
        col_ok[0] = out_col_reg != '0;
        col_ok[1] = 1'b1;
        col_ok[2] = ({1'b0, out_col_reg} + EW'(1)) < eff_w;
    end

    // Sum each channel over the window and divide by nine
    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (row_ok[r] && col_ok[c])
                begin
                    sum_r = sum_r + SUM_W'(win_next[r*3 + c][RGB_W-1 -: CHAN_W]);
                    sum_g = sum_g + SUM_W'(win_next[r*3 + c][2*CHAN_W-1 -: CHAN_W]);
                    sum_b = sum_b + SUM_W'(win_next[r*3 + c][CHAN_W-1 -: CHAN_W]);
                end
            end
        end
        blur_word = {div9(sum_r), div9(sum_g), div9(sum_b), ALPHA_OPAQUE};
    end

    assign out_col_inc = {1'b0, out_col_reg} + EW'(1);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_W'(RESET_WIDTH);
            frame_height_reg <= HEIGHT_W'(RESET_HEIGHT);
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            fwd_hit_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            // Advance positions; a register write starts a new frame
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            if (cfg_write)
            begin
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else if (s1_adv && s1_emit)
            begin
                if (s1_last)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                else if (out_col_inc >= eff_w)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + HEIGHT_W'(1);
                end
                else
                begin
                    out_col_reg <= out_col_inc[COL_W-1:0];
                end
            end

            // Register writes
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[WIDTH_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[HEIGHT_W-1:0];
                    default:          frame_width_reg  <= frame_width_reg;
                endcase
            end

            // Stage 1 occupancy and read bypass flag
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_adv && (s1_col_reg == acc_col);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            // Output handshake
            if (s1_adv && s1_emit)
                out_valid_reg <= 1'b1;
            else if (blur_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= (pixel_item.operation == OP_DRAIN) ? '0
                            : pixel_item.pixel_word[PIXEL_W-1:CHAN_W];
            s1_col_reg   <= acc_col;
            s1_row_reg   <= acc_row;
            fwd_data_reg <= line_wdata;
        end
        if (s1_adv)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
        if (s1_adv && s1_emit)
        begin
            out_item_reg.blurred_word <= blur_word;
            out_item_reg.frame_end    <= s1_last;
        end
    end

    assign blur_valid = out_valid_reg;
    assign blur_item  = out_item_reg;

endmodule

// ===== rtl/bblur_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value while no read is requested. A read of the address being written in
// the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module bblur_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bblur_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_checker: port-level checks for the 3x3 box blur
// Watches the item channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module bblur_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  pixel_valid,
    input logic                  pixel_ready,
    input logic                  blur_valid,
    input logic                  blur_ready,
    input bblur_pkg::blur_item_t blur_item
);

    import bblur_pkg::*;

    // Hold a stalled result item
    assert property (@(posedge clk) disable iff (!rst_n)
        blur_valid && !blur_ready |=> blur_valid && $stable(blur_item))
        else $error("stalled result item changed or dropped");

    // Every result is opaque
    assert property (@(posedge clk) disable iff (!rst_n)
        blur_valid |-> blur_item.blurred_word[CHAN_W-1:0] == ALPHA_OPAQUE)
        else $error("result alpha byte is not opaque");

    // Take input whenever the result register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !blur_valid |-> pixel_ready)
        else $error("input stalled with empty result register");

    // A fresh result must match an earlier accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(blur_valid) |-> $past(pixel_valid && pixel_ready, 2))
        else $error("result appeared without a matching accepted item");

endmodule

bind box_blur_3x3_rgb_top bblur_checker u_bblur_checker (.*);
